/* design/nir_pkg.sv */
// Shared types and constants for the NEC infrared frame decoder.
package nir_pkg;

  // Field widths.
  localparam int TICK_W    = 15;
  localparam int CODE_W    = 16;
  localparam int DATA_BITS = 2 * CODE_W;

  // Burst lengths that carry a result, and the default pair counter saturation value.
  localparam int NORMAL_PAIRS  = 34;
  localparam int REPEAT_PAIRS  = 2;
  localparam int MAX_PAIRS_DEF = 64;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_TOLERANCE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEADER_MARK  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LEADER_SPACE = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPEAT_SPACE = 3'd3;
  localparam logic [IDX_W-1:0] REG_BIT_MARK     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ZERO_SPACE   = 3'd5;
  localparam logic [IDX_W-1:0] REG_ONE_SPACE    = 3'd6;

  // Register values after reset.
  localparam logic [TICK_W-1:0] TOLERANCE_RST    = 15'd200;
  localparam logic [TICK_W-1:0] LEADER_MARK_RST  = 15'd9000;
  localparam logic [TICK_W-1:0] LEADER_SPACE_RST = 15'd4500;
  localparam logic [TICK_W-1:0] REPEAT_SPACE_RST = 15'd2250;
  localparam logic [TICK_W-1:0] BIT_MARK_RST     = 15'd560;
  localparam logic [TICK_W-1:0] ZERO_SPACE_RST   = 15'd560;
  localparam logic [TICK_W-1:0] ONE_SPACE_RST    = 15'd1690;

  // Timing configuration as seen by the classifier.
  typedef struct packed {
    logic [TICK_W-1:0] tolerance_ticks;
    logic [TICK_W-1:0] leader_mark_ticks;
    logic [TICK_W-1:0] leader_space_ticks;
    logic [TICK_W-1:0] repeat_space_ticks;
    logic [TICK_W-1:0] bit_mark_ticks;
    logic [TICK_W-1:0] zero_space_ticks;
    logic [TICK_W-1:0] one_space_ticks;
  } cfg_t;

  // Window match flags for one pulse pair.
  typedef struct packed {
    logic lead_mark;
    logic lead_space;
    logic rep_space;
    logic bit_mark;
    logic zero_space;
    logic one_space;
  } hit_t;

endpackage

/* design/nir_pulse_if.sv */
// Channel interface that carries one mark/space pulse pair per transfer.
interface nir_pulse_if;
  import nir_pkg::*;

  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] mark_ticks;
  logic [TICK_W-1:0] space_ticks;
  logic              end_of_burst;

  modport source (output valid, output mark_ticks, output space_ticks,
                  output end_of_burst, input ready);
  modport sink   (input valid, input mark_ticks, input space_ticks,
                  input end_of_burst, output ready);
endinterface

/* design/nir_frame_if.sv */
// Channel interface that carries one decoded frame per transfer.
interface nir_frame_if;
  import nir_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] address;
  logic [CODE_W-1:0] command;
  logic              is_repeat;

  modport source (output valid, output address, output command,
                  output is_repeat, input ready);
  modport sink   (input valid, input address, input command,
                  input is_repeat, output ready);
endinterface

/* design/nir_classify.sv */
// Window compares of one pulse pair against every nominal duration.
module nir_classify (
  input  logic [nir_pkg::TICK_W-1:0] mark_ticks,
  input  logic [nir_pkg::TICK_W-1:0] space_ticks,
  input  nir_pkg::cfg_t              cfg,
  output nir_pkg::hit_t              hit
);
  import nir_pkg::*;

  // True when got lies strictly inside nom +/- tol; never when tol exceeds nom.
  function automatic logic win_match(input logic [TICK_W-1:0] got,
                                     input logic [TICK_W-1:0] nom,
                                     input logic [TICK_W-1:0] tol);
    logic [TICK_W:0] lo;
    logic [TICK_W:0] hi;
    logic [TICK_W:0] g;
    lo = {1'b0, nom} - {1'b0, tol};
    hi = {1'b0, nom} + {1'b0, tol};
    g  = {1'b0, got};
    if (tol > nom) begin
      return 1'b0;
    end
    return (g > lo) && (g < hi);
  endfunction

  // Six independent compares, one per nominal duration.
  always_comb begin
    hit.lead_mark  = win_match(mark_ticks,  cfg.leader_mark_ticks,  cfg.tolerance_ticks);
    hit.lead_space = win_match(space_ticks, cfg.leader_space_ticks, cfg.tolerance_ticks);
    hit.rep_space  = win_match(space_ticks, cfg.repeat_space_ticks, cfg.tolerance_ticks);
    hit.bit_mark   = win_match(mark_ticks,  cfg.bit_mark_ticks,     cfg.tolerance_ticks);
    hit.zero_space = win_match(space_ticks, cfg.zero_space_ticks,   cfg.tolerance_ticks);
    hit.one_space  = win_match(space_ticks, cfg.one_space_ticks,    cfg.tolerance_ticks);
  end

endmodule

/* design/nec_ir_frame_decoder.sv */
// Top level of the NEC infrared frame decoder.
//
// The pulse channel takes one mark/space pair per transfer, in microsecond
// ticks, with end_of_burst set on the last pair of a burst. The frame channel
// gives address, command and is_repeat once per accepted burst that decodes:
// a 34-pair normal frame or a 2-pair repeat frame. Timing windows are set
// through the APB registers; write them only while the block is idle.
// A pair is taken into an input register, then classified and folded into
// the burst state when the output register can load; the same step loads
// the output register with any result. One pair is accepted every cycle
// while the frame receiver does not stall; the throughput is set by the
// single classify and update step between the two registers.
// Reset clears the burst state, the held code and both valid flags, and
// loads the nominal NEC timings. When the frame receiver stalls, the output
// register holds its result and the input register fills, after which the
// pulse channel is held off until the result is taken.
module nec_ir_frame_decoder #(
  parameter int unsigned MAX_PAIRS = nir_pkg::MAX_PAIRS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  nir_pulse_if.sink                  pulse,
  nir_frame_if.source                frame,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nir_pkg::ADDR_W-1:0] paddr,
  input  logic [nir_pkg::DATA_W-1:0] pwdata,
  output logic [nir_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import nir_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int POS_W = $clog2(DATA_BITS);

  logic [IDX_W-1:0] reg_idx;
  cfg_t             cfg;

  logic              s1_valid;
  logic [TICK_W-1:0] s1_mark;
  logic [TICK_W-1:0] s1_space;
  logic              s1_last;
  logic              out_free;
  logic              fire;
  hit_t              hit;

  logic [CNT_W-1:0]     pair_count;
  logic [CNT_W-1:0]     pair_count_next;
  logic                 leader_ok;
  logic                 leader_ok_next;
  logic                 repeat_lead_ok;
  logic                 repeat_lead_ok_next;
  logic                 bit_error;
  logic                 bit_error_next;
  logic [DATA_BITS-1:0] shift_bits;
  logic [DATA_BITS-1:0] shift_bits_next;
  logic [CODE_W-1:0]    held_address;
  logic [CODE_W-1:0]    held_address_next;
  logic [CODE_W-1:0]    held_command;
  logic [CODE_W-1:0]    held_command_next;
  logic [POS_W-1:0]     bit_pos;
  logic                 emit;
  logic                 emit_repeat;

  logic              out_valid;
  logic [CODE_W-1:0] out_address;
  logic [CODE_W-1:0] out_command;
  logic              out_is_repeat;

  // Configuration registers, written on the APB access cycle.
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance_ticks    <= TOLERANCE_RST;
      cfg.leader_mark_ticks  <= LEADER_MARK_RST;
      cfg.leader_space_ticks <= LEADER_SPACE_RST;
      cfg.repeat_space_ticks <= REPEAT_SPACE_RST;
      cfg.bit_mark_ticks     <= BIT_MARK_RST;
      cfg.zero_space_ticks   <= ZERO_SPACE_RST;
      cfg.one_space_ticks    <= ONE_SPACE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_TOLERANCE:    cfg.tolerance_ticks    <= pwdata[TICK_W-1:0];
        REG_LEADER_MARK:  cfg.leader_mark_ticks  <= pwdata[TICK_W-1:0];
        REG_LEADER_SPACE: cfg.leader_space_ticks <= pwdata[TICK_W-1:0];
        REG_REPEAT_SPACE: cfg.repeat_space_ticks <= pwdata[TICK_W-1:0];
        REG_BIT_MARK:     cfg.bit_mark_ticks     <= pwdata[TICK_W-1:0];
        REG_ZERO_SPACE:   cfg.zero_space_ticks   <= pwdata[TICK_W-1:0];
        REG_ONE_SPACE:    cfg.one_space_ticks    <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back; unused addresses read as zero.
  always_comb begin
    case (reg_idx)
      REG_TOLERANCE:    prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.tolerance_ticks};
      REG_LEADER_MARK:  prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.leader_mark_ticks};
      REG_LEADER_SPACE: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.leader_space_ticks};
      REG_REPEAT_SPACE: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.repeat_space_ticks};
      REG_BIT_MARK:     prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.bit_mark_ticks};
      REG_ZERO_SPACE:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.zero_space_ticks};
      REG_ONE_SPACE:    prdata = {{(DATA_W-TICK_W){1'b0}}, cfg.one_space_ticks};
      default:          prdata = '0;
    endcase
  end

  // Handshake: the update stage moves whenever the output register can load.
  assign out_free    = !out_valid || frame.ready;
  assign fire        = s1_valid && out_free;
  assign pulse.ready = !s1_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pulse.ready) begin
      s1_valid <= pulse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse.valid && pulse.ready) begin
      s1_mark  <= pulse.mark_ticks;
      s1_space <= pulse.space_ticks;
      s1_last  <= pulse.end_of_burst;
    end
  end

  // Window compares on the registered pair.
  nir_classify u_classify (
    .mark_ticks  (s1_mark),
    .space_ticks (s1_space),
    .cfg         (cfg),
    .hit         (hit)
  );

  // Burst state update and frame judgment for the registered pair.
  assign bit_pos = POS_W'(pair_count - CNT_W'(1));

  always_comb begin
    pair_count_next     = pair_count;
    leader_ok_next      = leader_ok;
    repeat_lead_ok_next = repeat_lead_ok;
    bit_error_next      = bit_error;
    shift_bits_next     = shift_bits;
    held_address_next   = held_address;
    held_command_next   = held_command;
    emit                = 1'b0;
    emit_repeat         = 1'b0;

    if (pair_count == '0) begin
      leader_ok_next      = hit.lead_mark && hit.lead_space;
      repeat_lead_ok_next = hit.lead_mark && hit.rep_space;
    end else if (pair_count <= CNT_W'(DATA_BITS)) begin
      if (hit.bit_mark && hit.one_space) begin
        shift_bits_next[bit_pos] = 1'b1;
      end else if (hit.bit_mark && hit.zero_space) begin
        shift_bits_next[bit_pos] = 1'b0;
      end else begin
        bit_error_next = 1'b1;
      end
    end

    if (pair_count < CNT_W'(MAX_PAIRS)) begin
      pair_count_next = pair_count + CNT_W'(1);
    end

    if (s1_last) begin
      if (pair_count_next == CNT_W'(NORMAL_PAIRS) && leader_ok_next && !bit_error_next) begin
        held_address_next = shift_bits_next[CODE_W-1:0];
        held_command_next = shift_bits_next[DATA_BITS-1:CODE_W];
        emit              = 1'b1;
      end else if (pair_count_next == CNT_W'(REPEAT_PAIRS) && repeat_lead_ok_next) begin
        emit        = 1'b1;
        emit_repeat = 1'b1;
      end
      pair_count_next     = '0;
      leader_ok_next      = 1'b0;
      repeat_lead_ok_next = 1'b0;
      bit_error_next      = 1'b0;
      shift_bits_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count     <= '0;
      leader_ok      <= 1'b0;
      repeat_lead_ok <= 1'b0;
      bit_error      <= 1'b0;
      shift_bits     <= '0;
      held_address   <= '0;
      held_command   <= '0;
    end else if (fire) begin
      pair_count     <= pair_count_next;
      leader_ok      <= leader_ok_next;
      repeat_lead_ok <= repeat_lead_ok_next;
      bit_error      <= bit_error_next;
      shift_bits     <= shift_bits_next;
      held_address   <= held_address_next;
      held_command   <= held_command_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_address   <= held_address_next;
      out_command   <= held_command_next;
      out_is_repeat <= emit_repeat;
    end
  end

  assign frame.valid     = out_valid;
  assign frame.address   = out_address;
  assign frame.command   = out_command;
  assign frame.is_repeat = out_is_repeat;

  // The pair counter never passes its saturation value.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= CNT_W'(MAX_PAIRS))
    else $error("pair counter above saturation value");

  // The last pair of a burst always returns the counter to zero.
  a_burst_clear: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last |=> pair_count == '0)
    else $error("burst state not cleared after last pair");

  // A result is only produced by the last pair of a burst.
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    fire && emit |-> s1_last)
    else $error("result produced before end of burst");

  // A waiting repeat result carries the held code.
  a_repeat_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_is_repeat |->
      out_address == held_address && out_command == held_command)
    else $error("repeat result differs from held code");

  // The pulse channel is only held off while the input register is full.
  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !pulse.ready |-> s1_valid && out_valid)
    else $error("pulse channel stalled with no work pending");

endmodule
